@@ rtl/smce_pkg.sv @@
`timescale 1ns / 1ps

package smce_pkg;

   localparam int MAX_CLASSES_DEFAULT = 16;

   // batch_rows register width
   localparam int BATCH_W = 11;

   // ln(2) in Q.32
   localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

   // just under 2^62 / LN2_Q32, so the range-reduction quotient estimate is
   // never high and at most one below the true quotient
   localparam logic [31:0] LN2_RECIP_Q62 = 32'd1549080000;

   // highest Taylor order for exp(-r)
   localparam int TAYLOR_TERMS = 12;

   // row sum of exponentials, Q.32, sized for up to 64 classes
   localparam int SUM_W = 39;

   // divider dividend and quotient width
   localparam int DIV_W = 48;

   localparam logic [23:0] LOSS_MAX = 24'hFFFFFF;
   localparam logic [15:0] ONE_Q15 = 16'd32768;

endpackage

@@ rtl/softmax_cross_entropy_row.sv @@
`timescale 1ns / 1ps

// Softmax with cross-entropy loss over one row of class scores. Each req item
// carries a Q8.8 logit and a Q1.15 target; items are buffered (up to
// MAX_CLASSES, extra ones are dropped but their row_end/batch_end still act)
// until an item with row_end set. The row is then worked off on one shared
// 32x32 multiplier and one shared 48-step restoring divider: a first pass
// forms exp(logit - max) for every element (range reduction by ln2 through a
// reciprocal multiply and one correction step, then an order-12 Taylor series),
// then ln of the row sum is found by squaring, then a second pass emits one
// rsp item per buffered element in arrival order with the probability, the
// gradient (p - t) / batch_rows and the last flag. The loss -t*ln(p) is
// accumulated in log-sum-exp form; the mean batch loss (Q8.16, saturating)
// rides on the final item of a row with batch_end set.
// Timing: while no row is being worked off, items without row_end are taken
// one per cycle. Nearly all of a row's time is spent in the divider (one
// quotient bit per cycle, 11 divisions per exponential that runs the series,
// 2 or 3 per emitted item), plus the time the consumer stalls. An element
// more than about 22 below the row maximum skips the series. req_stall is
// high after the row_end item is taken until the row's last rsp item is
// taken. batch_rows is written through the csr channel, which is always
// ready; a value of zero acts as one.
module softmax_cross_entropy_row #(
   parameter int MAX_CLASSES = smce_pkg::MAX_CLASSES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [15:0]            req_logit,
   input  logic        [15:0]            req_target,
   input  logic                          req_row_end,
   input  logic                          req_batch_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic        [15:0]            rsp_probability,
   output logic signed [16:0]            rsp_gradient,
   output logic        [23:0]            rsp_batch_loss,
   output logic                          rsp_loss_valid,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [smce_pkg::BATCH_W-1:0]  csr_data
);

   localparam int IDX_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int FILL_W = $clog2(MAX_CLASSES + 1);
   localparam int SUM_W  = smce_pkg::SUM_W;
   localparam int DIV_W  = smce_pkg::DIV_W;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DIV,
      S_EXP_RD,
      S_EXP_LD,
      S_EXP_K,
      S_EXP_R,
      S_EXP_MUL,
      S_EXP_TDIV,
      S_EXP_TERM,
      S_EXP_SH,
      S_LN_INIT,
      S_LN_NORM,
      S_LN_SQ,
      S_LN_BIT,
      S_LN_MUL,
      S_LN_FIN,
      S_OUT_RD,
      S_OUT_Y,
      S_OUT_G,
      S_OUT_L,
      S_OUT_ACC,
      S_OUT_LOSS,
      S_OUT_WAIT
   } state_type;

   state_type state_ff, ret_ff;

   // row buffers
   logic signed [15:0] logit_mem [MAX_CLASSES];
   logic        [15:0] target_mem [MAX_CLASSES];
   logic        [32:0] exp_mem [MAX_CLASSES];
   logic signed [15:0] logit_rd_ff;
   logic        [15:0] target_rd_ff;
   logic        [32:0] exp_rd_ff;

   logic [FILL_W-1:0]        fill_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic signed [15:0]       max_ff;
   logic [31:0]              loss_sum_ff;
   logic                     batch_end_ff;
   logic [smce_pkg::BATCH_W-1:0] batch_rows_ff;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_ff;

   // shared divider
   logic [DIV_W-1:0] dq_ff;
   logic [SUM_W-1:0] rem_ff, den_ff;
   logic [5:0]       div_cnt_ff;
   logic [SUM_W:0]   div_shift, div_diff;
   logic             div_ge;

   // exponential
   logic [15:0] m_ff;
   logic [15:0] gap_now;
   logic [8:0]  k_ff;
   logic [8:0]  k_next;
   logic [39:0] red_full;
   logic        red_ge;
   logic [31:0] red_r;
   logic [31:0] r_ff;
   logic [31:0] term_ff;
   logic [32:0] taylor_ff;
   logic [3:0]  n_ff;
   logic [32:0] exp_val;
   logic [SUM_W-1:0] sum_s_ff;

   // logarithm
   logic [SUM_W-1:0] lm_ff;
   logic [5:0]       p_ff;
   logic [15:0]      frac_ff;
   logic [3:0]       sq_ff;
   logic [21:0]      lns_ff;
   logic [32:0]      sq_val;

   // result path
   logic [15:0]        y_ff;
   logic               neg_ff;
   logic [16:0]        diff17, mag17;
   logic [24:0]        nl;
   logic [25:0]        loss_term;
   logic [32:0]        loss_acc;
   logic [31:0]        loss_sum_in;
   logic [smce_pkg::BATCH_W-1:0] b_eff;
   logic               last_elem;
   logic [15:0]        tgt_clamp;
   logic               store_we, exp_we;

   logic               rsp_valid_ff, rsp_last_ff, rsp_loss_valid_ff;
   logic [15:0]        rsp_prob_ff;
   logic signed [16:0] rsp_grad_ff;
   logic [23:0]        rsp_loss_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_probability = rsp_prob_ff;
   assign rsp_gradient    = rsp_grad_ff;
   assign rsp_batch_loss  = rsp_loss_ff;
   assign rsp_loss_valid  = rsp_loss_valid_ff;
   assign rsp_last        = rsp_last_ff;

   assign b_eff     = (batch_rows_ff == '0) ? smce_pkg::BATCH_W'(1) : batch_rows_ff;
   assign tgt_clamp = (req_target > smce_pkg::ONE_Q15) ? smce_pkg::ONE_Q15 : req_target;
   assign last_elem = ((FILL_W'(idx_ff) + FILL_W'(1)) == fill_ff);
   assign store_we  = (state_ff == S_IDLE) && req_valid
                      && (fill_ff < FILL_W'(MAX_CLASSES));
   assign exp_we    = (state_ff == S_EXP_SH);

   // restoring divider step
   assign div_shift = {rem_ff, dq_ff[DIV_W-1]};
   assign div_diff  = div_shift - {1'b0, den_ff};
   assign div_ge    = (div_shift >= {1'b0, den_ff});

   // range reduction: the estimated quotient is at most one low, fix it here
   assign gap_now  = 16'(max_ff - logit_rd_ff);
   assign red_full = {m_ff, 24'b0} - mul_ff[39:0];
   assign red_ge   = (red_full >= 40'(smce_pkg::LN2_Q32));
   assign red_r    = red_ge ? 32'(red_full - 40'(smce_pkg::LN2_Q32)) : red_full[31:0];
   assign k_next   = k_ff + 9'(red_ge);

   assign exp_val = (k_ff >= 9'd32) ? 33'd0 : (taylor_ff >> k_ff[4:0]);
   assign sq_val  = mul_ff[63:31];

   assign diff17 = {1'b0, y_ff} - {1'b0, target_rd_ff};
   assign mag17  = diff17[16] ? (17'd0 - diff17) : diff17;

   assign nl        = {3'b0, lns_ff} + {1'b0, m_ff, 8'b0};
   assign loss_term = 26'((mul_ff[40:0] + 41'd16384) >> 15);
   assign loss_acc  = {1'b0, loss_sum_ff} + 33'(loss_term);
   assign loss_sum_in = loss_acc[32] ? 32'hFFFFFFFF : loss_acc[31:0];

   // select multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_EXP_LD: begin
            mul_a = {16'b0, gap_now};
            mul_b = smce_pkg::LN2_RECIP_Q62;
         end
         S_EXP_K: begin
            mul_a = {23'b0, mul_ff[46:38]};
            mul_b = smce_pkg::LN2_Q32;
         end
         S_EXP_MUL: begin
            mul_a = term_ff;
            mul_b = r_ff;
         end
         S_LN_SQ: begin
            mul_a = lm_ff[31:0];
            mul_b = lm_ff[31:0];
         end
         S_LN_MUL: begin
            mul_a = {10'b0, p_ff, frac_ff};
            mul_b = smce_pkg::LN2_Q32;
         end
         S_OUT_L: begin
            mul_a = {16'b0, target_rd_ff};
            mul_b = {7'b0, nl};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         logit_mem[fill_ff[IDX_W-1:0]]  <= req_logit;
         target_mem[fill_ff[IDX_W-1:0]] <= tgt_clamp;
      end
      if (exp_we) begin
         exp_mem[idx_ff] <= exp_val;
      end
      logit_rd_ff  <= logit_mem[idx_ff];
      target_rd_ff <= target_mem[idx_ff];
      exp_rd_ff    <= exp_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         ret_ff            <= S_IDLE;
         fill_ff           <= '0;
         idx_ff            <= '0;
         max_ff            <= 16'sh8000;
         loss_sum_ff       <= '0;
         batch_end_ff      <= 1'b0;
         batch_rows_ff     <= smce_pkg::BATCH_W'(1);
         rsp_valid_ff      <= 1'b0;
         rsp_last_ff       <= 1'b0;
         rsp_loss_valid_ff <= 1'b0;
         rsp_loss_ff       <= '0;
      end else begin
         // hold the product while the divider runs
         if (state_ff != S_DIV) begin
            mul_ff <= mul_a * mul_b;
         end
         if (csr_valid && csr_ready) begin
            batch_rows_ff <= csr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (store_we) begin
                     fill_ff <= fill_ff + FILL_W'(1);
                     if (req_logit > max_ff) begin
                        max_ff <= req_logit;
                     end
                  end
                  if (req_row_end) begin
                     batch_end_ff <= req_batch_end;
                     idx_ff       <= '0;
                     sum_s_ff     <= '0;
                     state_ff     <= S_EXP_RD;
                  end
               end
            end
            S_DIV: begin
               rem_ff     <= div_ge ? div_diff[SUM_W-1:0] : div_shift[SUM_W-1:0];
               dq_ff      <= {dq_ff[DIV_W-2:0], div_ge};
               div_cnt_ff <= div_cnt_ff + 6'd1;
               if (div_cnt_ff == 6'(DIV_W - 1)) begin
                  state_ff <= ret_ff;
               end
            end
            S_EXP_RD: begin
               state_ff <= S_EXP_LD;
            end
            S_EXP_LD: begin
               // estimate (max - logit) / ln2 by reciprocal multiply
               m_ff     <= gap_now;
               state_ff <= S_EXP_K;
            end
            S_EXP_K: begin
               k_ff     <= mul_ff[46:38];
               state_ff <= S_EXP_R;
            end
            S_EXP_R: begin
               k_ff      <= k_next;
               r_ff      <= red_r;
               term_ff   <= red_r;
               taylor_ff <= 33'h1_0000_0000 - {1'b0, red_r};
               n_ff      <= 4'd2;
               state_ff  <= (k_next >= 9'd32) ? S_EXP_SH : S_EXP_MUL;
            end
            S_EXP_MUL: begin
               state_ff <= S_EXP_TDIV;
            end
            S_EXP_TDIV: begin
               dq_ff      <= DIV_W'(mul_ff[63:32]);
               den_ff     <= SUM_W'(n_ff);
               rem_ff     <= '0;
               div_cnt_ff <= '0;
               ret_ff     <= S_EXP_TERM;
               state_ff   <= S_DIV;
            end
            S_EXP_TERM: begin
               term_ff   <= dq_ff[31:0];
               taylor_ff <= n_ff[0] ? (taylor_ff - {1'b0, dq_ff[31:0]})
                                    : (taylor_ff + {1'b0, dq_ff[31:0]});
               n_ff      <= n_ff + 4'd1;
               state_ff  <= (n_ff == 4'(smce_pkg::TAYLOR_TERMS)) ? S_EXP_SH : S_EXP_MUL;
            end
            S_EXP_SH: begin
               sum_s_ff <= sum_s_ff + SUM_W'(exp_val);
               if (last_elem) begin
                  state_ff <= S_LN_INIT;
               end else begin
                  idx_ff   <= idx_ff + IDX_W'(1);
                  state_ff <= S_EXP_RD;
               end
            end
            S_LN_INIT: begin
               lm_ff    <= sum_s_ff;
               p_ff     <= '0;
               frac_ff  <= '0;
               state_ff <= S_LN_NORM;
            end
            S_LN_NORM: begin
               // one shift per cycle until the mantissa sits in [1,2)
               if ((lm_ff >= (SUM_W'(1) << 33)) && (p_ff < 6'd32)) begin
                  lm_ff <= lm_ff >> 1;
                  p_ff  <= p_ff + 6'd1;
               end else begin
                  lm_ff    <= lm_ff >> 1;
                  sq_ff    <= '0;
                  state_ff <= S_LN_SQ;
               end
            end
            S_LN_SQ: begin
               state_ff <= S_LN_BIT;
            end
            S_LN_BIT: begin
               frac_ff <= {frac_ff[14:0], sq_val[32]};
               lm_ff   <= sq_val[32] ? SUM_W'(sq_val[32:1]) : SUM_W'(sq_val);
               sq_ff   <= sq_ff + 4'd1;
               state_ff <= (sq_ff == 4'd15) ? S_LN_MUL : S_LN_SQ;
            end
            S_LN_MUL: begin
               state_ff <= S_LN_FIN;
            end
            S_LN_FIN: begin
               lns_ff   <= 22'((mul_ff + 64'h8000_0000) >> 32);
               idx_ff   <= '0;
               state_ff <= S_OUT_RD;
            end
            S_OUT_RD: begin
               state_ff <= S_OUT_Y;
            end
            S_OUT_Y: begin
               m_ff       <= gap_now;
               dq_ff      <= (DIV_W'(exp_rd_ff) << 15) + DIV_W'(sum_s_ff >> 1);
               den_ff     <= sum_s_ff;
               rem_ff     <= '0;
               div_cnt_ff <= '0;
               ret_ff     <= S_OUT_G;
               state_ff   <= S_DIV;
            end
            S_OUT_G: begin
               y_ff        <= dq_ff[15:0];
               rsp_prob_ff <= dq_ff[15:0];
               state_ff    <= S_OUT_L;
            end
            S_OUT_L: begin
               // gradient magnitude over batch_rows, rounded
               neg_ff     <= diff17[16];
               dq_ff      <= DIV_W'(mag17) + DIV_W'(b_eff >> 1);
               den_ff     <= SUM_W'(b_eff);
               rem_ff     <= '0;
               div_cnt_ff <= '0;
               ret_ff     <= S_OUT_ACC;
               state_ff   <= S_DIV;
            end
            S_OUT_ACC: begin
               rsp_grad_ff <= neg_ff ? -$signed(dq_ff[16:0]) : $signed(dq_ff[16:0]);
               loss_sum_ff <= loss_sum_in;
               rsp_last_ff <= last_elem;
               if (last_elem && batch_end_ff) begin
                  dq_ff      <= DIV_W'(loss_sum_in) + DIV_W'(b_eff >> 1);
                  den_ff     <= SUM_W'(b_eff);
                  rem_ff     <= '0;
                  div_cnt_ff <= '0;
                  ret_ff     <= S_OUT_LOSS;
                  state_ff   <= S_DIV;
               end else begin
                  rsp_loss_ff       <= '0;
                  rsp_loss_valid_ff <= 1'b0;
                  rsp_valid_ff      <= 1'b1;
                  state_ff          <= S_OUT_WAIT;
               end
            end
            S_OUT_LOSS: begin
               rsp_loss_ff       <= (dq_ff[DIV_W-1:24] != '0) ? smce_pkg::LOSS_MAX
                                                              : dq_ff[23:0];
               rsp_loss_valid_ff <= 1'b1;
               loss_sum_ff       <= '0;
               rsp_valid_ff      <= 1'b1;
               state_ff          <= S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     fill_ff  <= '0;
                     max_ff   <= 16'sh8000;
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + IDX_W'(1);
                     state_ff <= S_OUT_RD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_valid_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_OUT_WAIT))
      else $error("rsp_valid outside output wait");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_CLASSES))
      else $error("fill count beyond buffer depth");

   a_loss_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_loss_valid) |-> rsp_last)
      else $error("loss on an item that does not end its row");

   a_row_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> (fill_ff == '0 && !req_stall))
      else $error("row state not cleared after its last item");

   a_prob_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_probability <= smce_pkg::ONE_Q15))
      else $error("probability above one");
`endif

endmodule
